// File: src/code_relocation_fixup_defines.svh
// ----------------------------------------------------------------------------
// code relocation fixup assertion macros
// concurrent checks clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef CODE_RELOCATION_FIXUP_DEFINES_SVH
`define CODE_RELOCATION_FIXUP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CRF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CRF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define CRF_ASSERT_SAME(lbl, ante, cons, msg)
`define CRF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: src/crf_pkg.sv
// ----------------------------------------------------------------------------
// crf_pkg
// shared types and constants of the code relocation fixup pipeline
// ----------------------------------------------------------------------------
package crf_pkg;

	// fixup kinds after type decode
	typedef enum logic [2:0] {
		KIND_NONE = 3'd0,
		KIND_BR26 = 3'd1,
		KIND_PG21 = 3'd2,
		KIND_LO12 = 3'd3,
		KIND_X86  = 3'd4
	} crf_kind_t;

	// beat carried from the value stage to the patch stage
	typedef struct packed {
		crf_kind_t   kind;
		logic [31:0] word;
		logic [63:0] value;
		logic [63:0] place;
	} crf_item_t;

	// mach-o aarch64 types
	localparam logic [9:0] MACHO_ARM_BR26 = 10'd2;
	localparam logic [9:0] MACHO_ARM_PG21 = 10'd3;
	localparam logic [9:0] MACHO_ARM_LO12 = 10'd4;

	// elf aarch64 types
	localparam logic [9:0] ELF_ARM_CALL26   = 10'd283;
	localparam logic [9:0] ELF_ARM_JUMP26   = 10'd282;
	localparam logic [9:0] ELF_ARM_PAGE21   = 10'd275;
	localparam logic [9:0] ELF_ARM_LO12     = 10'd277;
	localparam logic [9:0] ELF_ARM_LO12_LO  = 10'd284;
	localparam logic [9:0] ELF_ARM_LO12_HI  = 10'd286;

	// x86-64 types
	localparam logic [9:0] MACHO_X86_SIGNED = 10'd1;
	localparam logic [9:0] MACHO_X86_BRANCH = 10'd2;
	localparam logic [9:0] ELF_X86_PC32     = 10'd2;
	localparam logic [9:0] ELF_X86_PLT32    = 10'd4;

	// instruction field masks
	localparam logic [31:0] BR26_KEEP  = 32'hfc000000;
	localparam logic [31:0] PG21_KEEP  = 32'h9f00001f;
	localparam logic [31:0] LO12_KEEP  = 32'hffc003ff;
	localparam logic [31:0] LDST_MASK  = 32'h3b000000;
	localparam logic [31:0] LDST_MATCH = 32'h39000000;
	localparam logic [31:0] Q128_MASK  = 32'h04800000;

endpackage

// File: src/crf_value_stage.sv
// ----------------------------------------------------------------------------
// crf_value_stage
// decodes the fixup kind and forms target plus addend into the s2 register
// ----------------------------------------------------------------------------
module crf_value_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                v_s1,
	input  logic                arch_s1,
	input  logic                format_s1,
	input  logic [9:0]          reloc_type_s1,
	input  logic                has_literal_s1,
	input  logic [31:0]         word_s1,
	input  logic [63:0]         target_s1,
	input  logic [63:0]         place_s1,
	input  logic [63:0]         addend_s1,
	output logic                v_s2,
	output crf_pkg::crf_item_t  item_s2
);
	import crf_pkg::*;

	`include "code_relocation_fixup_defines.svh"

	crf_kind_t   kind_d;
	logic [63:0] add_b;
	logic [63:0] add_c;
	logic [63:0] csa_sum;
	logic [63:0] csa_cy;
	logic [63:0] value_d;

	// relocation type decode
	always_comb begin
		kind_d = KIND_NONE;
		if (arch_s1) begin
			if (format_s1) begin
				if (reloc_type_s1 == ELF_X86_PC32 || reloc_type_s1 == ELF_X86_PLT32)
					kind_d = KIND_X86;
			end else begin
				if (reloc_type_s1 == MACHO_X86_SIGNED || reloc_type_s1 == MACHO_X86_BRANCH)
					kind_d = KIND_X86;
			end
		end else if (format_s1) begin
			priority if (reloc_type_s1 == ELF_ARM_CALL26 || reloc_type_s1 == ELF_ARM_JUMP26)
				kind_d = KIND_BR26;
			else if (reloc_type_s1 == ELF_ARM_PAGE21)
				kind_d = KIND_PG21;
			else if (reloc_type_s1 == ELF_ARM_LO12 ||
			         (reloc_type_s1 >= ELF_ARM_LO12_LO && reloc_type_s1 <= ELF_ARM_LO12_HI))
				kind_d = KIND_LO12;
			else
				kind_d = KIND_NONE;
		end else begin
			priority if (reloc_type_s1 == MACHO_ARM_BR26)
				kind_d = KIND_BR26;
			else if (reloc_type_s1 == MACHO_ARM_PG21)
				kind_d = KIND_PG21;
			else if (reloc_type_s1 == MACHO_ARM_LO12)
				kind_d = KIND_LO12;
			else
				kind_d = KIND_NONE;
		end
	end

	// addend selection: x86 always, aarch64 elf only without a literal
	assign add_b = (arch_s1 || (format_s1 && !has_literal_s1)) ? addend_s1 : 64'd0;
	// embedded addend for x86 mach-o
	assign add_c = (arch_s1 && !format_s1) ? {{32{word_s1[31]}}, word_s1} : 64'd0;

	// carry-save of three operands, then one adder
	assign csa_sum = target_s1 ^ add_b ^ add_c;
	assign csa_cy  = {((target_s1[62:0] & add_b[62:0]) | (target_s1[62:0] & add_c[62:0]) |
	                   (add_b[62:0] & add_c[62:0])), 1'b0};
	assign value_d = csa_sum + csa_cy;

	// s2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	// s2 payload
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s2.kind  <= kind_d;
			item_s2.word  <= word_s1;
			item_s2.value <= value_d;
			item_s2.place <= place_s1;
		end
	end

	`CRF_ASSERT_NEXT(a_s2_hold, v_s2 && !adv, v_s2 && $stable(item_s2), "s2 lost a stalled beat")

endmodule

// File: src/crf_patch_stage.sv
// ----------------------------------------------------------------------------
// crf_patch_stage
// forms the pc-relative delta, runs range and alignment checks, patches word
// ----------------------------------------------------------------------------
module crf_patch_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                v_s2,
	input  crf_pkg::crf_item_t  item_s2,
	output logic                out_valid,
	output logic [31:0]         word_out,
	output logic                ok
);
	import crf_pkg::*;

	`include "code_relocation_fixup_defines.svh"

	logic [63:0] delta;
	logic [51:0] pages;
	logic [11:0] low;
	logic [2:0]  sz;
	logic [11:0] low_mask;
	logic [11:0] low_sh;
	logic        is_ldst;
	logic        ok_d;
	logic [31:0] word_d;
	logic        valid_q;
	logic [31:0] word_q;
	logic        ok_q;

	// full delta and page delta
	assign delta = item_s2.value - item_s2.place;
	assign pages = item_s2.value[63:12] - item_s2.place[63:12];

	// page offset scaling for loads and stores
	assign low      = item_s2.value[11:0];
	assign is_ldst  = (item_s2.word & LDST_MASK) == LDST_MATCH;
	assign sz       = ((item_s2.word & Q128_MASK) == Q128_MASK) ? 3'd4
	                  : {1'b0, item_s2.word[31:30]};
	assign low_mask = (12'd1 << sz) - 12'd1;
	assign low_sh   = low >> sz;

	// check and patch per kind
	always_comb begin
		ok_d   = 1'b0;
		word_d = item_s2.word;
		unique case (item_s2.kind)
			KIND_BR26: begin
				if (delta[1:0] == 2'b00 &&
				    (delta[63:27] == '0 || delta[63:27] == '1)) begin
					ok_d   = 1'b1;
					word_d = (item_s2.word & BR26_KEEP) | {6'd0, delta[27:2]};
				end
			end
			KIND_PG21: begin
				if (pages[51:20] == '0 || pages[51:20] == '1) begin
					ok_d   = 1'b1;
					word_d = (item_s2.word & PG21_KEEP) |
					         {1'b0, pages[1:0], 5'd0, pages[20:2], 5'd0};
				end
			end
			KIND_LO12: begin
				if (is_ldst) begin
					if ((low & low_mask) == 12'd0) begin
						ok_d   = 1'b1;
						word_d = (item_s2.word & LO12_KEEP) | {10'd0, low_sh, 10'd0};
					end
				end else begin
					ok_d   = 1'b1;
					word_d = (item_s2.word & LO12_KEEP) | {10'd0, low, 10'd0};
				end
			end
			KIND_X86: begin
				if (delta[63:31] == '0 || delta[63:31] == '1) begin
					ok_d   = 1'b1;
					word_d = delta[31:0];
				end
			end
			default: begin
				ok_d   = 1'b0;
				word_d = item_s2.word;
			end
		endcase
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= v_s2;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (adv) begin
			word_q <= word_d;
			ok_q   <= ok_d;
		end
	end

	assign out_valid = valid_q;
	assign word_out  = word_q;
	assign ok        = ok_q;

	`CRF_ASSERT_SAME(a_fail_keeps_word, v_s2 && !ok_d, word_d == item_s2.word, "failed fixup altered word")
	`CRF_ASSERT_NEXT(a_none_fails, adv && v_s2 && item_s2.kind == KIND_NONE, out_valid && !ok, "unsupported type patched")
	`CRF_ASSERT_NEXT(a_ok_lands, adv && v_s2 && ok_d, out_valid && ok, "successful fixup lost")

endmodule

// File: src/code_relocation_fixup.sv
// ----------------------------------------------------------------------------
// code_relocation_fixup
// applies one aarch64 or x86-64 code relocation to a 32-bit word
// ----------------------------------------------------------------------------
// Three register stages: an input register, a value register holding the
// decoded kind and target plus addend, and a result register. A beat accepted
// passes through them in that order to out_valid, and one beat is taken every
// cycle while the result side keeps up. The whole pipeline holds as one while a
// result waits on out_ready, so in_ready follows out_ready combinationally
// whenever the result register is full. The 64-bit adder of the value stage and
// the 64-bit delta subtract of the patch stage set the clock.
module code_relocation_fixup (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        arch,
	input  logic        format,
	input  logic [9:0]  reloc_type,
	input  logic        has_literal,
	input  logic [31:0] word_in,
	input  logic [63:0] target,
	input  logic [63:0] place,
	input  logic [63:0] addend,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] word_out,
	output logic        ok
);
	import crf_pkg::*;

	`include "code_relocation_fixup_defines.svh"

	logic        adv;
	logic        v_s1;
	logic        arch_s1;
	logic        format_s1;
	logic [9:0]  reloc_type_s1;
	logic        has_literal_s1;
	logic [31:0] word_s1;
	logic [63:0] target_s1;
	logic [63:0] place_s1;
	logic [63:0] addend_s1;
	logic        v_s2;
	crf_item_t   item_s2;

	// pipeline moves unless a result beat is stuck
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			arch_s1        <= arch;
			format_s1      <= format;
			reloc_type_s1  <= reloc_type;
			has_literal_s1 <= has_literal;
			word_s1        <= word_in;
			target_s1      <= target;
			place_s1       <= place;
			addend_s1      <= addend;
		end
	end

	// kind decode and value sum
	crf_value_stage u_value (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.v_s1           (v_s1),
		.arch_s1        (arch_s1),
		.format_s1      (format_s1),
		.reloc_type_s1  (reloc_type_s1),
		.has_literal_s1 (has_literal_s1),
		.word_s1        (word_s1),
		.target_s1      (target_s1),
		.place_s1       (place_s1),
		.addend_s1      (addend_s1),
		.v_s2           (v_s2),
		.item_s2        (item_s2)
	);

	// checks and patch
	crf_patch_stage u_patch (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.v_s2      (v_s2),
		.item_s2   (item_s2),
		.out_valid (out_valid),
		.word_out  (word_out),
		.ok        (ok)
	);

	`CRF_ASSERT_NEXT(a_accept_lands, in_valid && in_ready, v_s1, "accepted beat missing from input register")
	`CRF_ASSERT_NEXT(a_s1_moves, v_s1 && adv, v_s2, "input register beat not passed on")

endmodule
